>>> design/c16b_pkg.sv
// Package: shared types, constants and helpers for the byte-wise CRC-16 block.
`timescale 1ns / 1ps
package c16b_pkg;

  localparam int unsigned CrcW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    VAR_CCITT_ONES = 2'd0,
    VAR_CCITT_ZERO = 2'd1,
    VAR_CCITT_MOD  = 2'd2,
    VAR_CRC16      = 2'd3
  } c16b_variant_t;

  typedef enum logic [1:0] {
    REG_VARIANT   = 2'd0,
    REG_LSB_FIRST = 2'd1,
    REG_INVERT    = 2'd2,
    REG_NONE      = 2'd3
  } c16b_reg_idx_t;

  typedef struct packed {
    c16b_variant_t variant;
    logic          lsb_first;
    logic          invert_result;
  } c16b_cfg_t;

  localparam logic [CrcW-1:0] PolyCcitt     = 16'h1021;
  localparam logic [CrcW-1:0] PolyCrc16     = 16'h8005;
  localparam logic [CrcW-1:0] PolyCcittRefl = 16'h8408;
  localparam logic [CrcW-1:0] PolyCrc16Refl = 16'hA001;
  localparam logic [CrcW-1:0] StartOnes     = 16'hFFFF;
  localparam logic [CrcW-1:0] StartMod      = 16'h1D0F;
  localparam logic [CrcW-1:0] StartModRefl  = 16'hF0B8;
  localparam logic [CrcW-1:0] StartZero     = 16'h0000;
  localparam logic [CrcW-1:0] InvertMask    = 16'hFFFF;

  function automatic logic [CrcW-1:0] start_value(input c16b_cfg_t cfg);
    logic [CrcW-1:0] s;
    case (cfg.variant)
      VAR_CCITT_ONES: s = StartOnes;
      VAR_CCITT_MOD:  s = cfg.lsb_first ? StartModRefl : StartMod;
      default:        s = StartZero;
    endcase
    return s;
  endfunction

endpackage

>>> design/c16b_apb_regs.sv
// Configuration register file behind an APB-style port.
`timescale 1ns / 1ps
module c16b_apb_regs
  import c16b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output c16b_cfg_t        cfg
);

  c16b_cfg_t     cfg_r, cfg_nxt;
  c16b_reg_idx_t idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = c16b_reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_VARIANT:   cfg_nxt.variant       = c16b_variant_t'(pwdata[1:0]);
        REG_LSB_FIRST: cfg_nxt.lsb_first     = pwdata[0];
        REG_INVERT:    cfg_nxt.invert_result = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VARIANT:   prdata = {{(DataW-2){1'b0}}, cfg_r.variant};
      REG_LSB_FIRST: prdata = {{(DataW-1){1'b0}}, cfg_r.lsb_first};
      REG_INVERT:    prdata = {{(DataW-1){1'b0}}, cfg_r.invert_result};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{variant: VAR_CCITT_ONES, lsb_first: 1'b0, invert_result: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/c16b_fold.sv
// Combinational 8-bit unrolled CRC-16 update, MSB-first or reflected.
`timescale 1ns / 1ps
module c16b_fold
  import c16b_pkg::*;
(
  input  logic [CrcW-1:0]  crc_in,
  input  logic [ByteW-1:0] data,
  input  c16b_cfg_t        cfg,
  output logic [CrcW-1:0]  crc_out
);

  always_comb begin
    logic [CrcW-1:0] c;
    logic [CrcW-1:0] poly;
    if (cfg.lsb_first) begin
      poly = (cfg.variant == VAR_CRC16) ? PolyCrc16Refl : PolyCcittRefl;
      c    = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
      for (int k = 0; k < ByteW; k++) begin
        c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
    end else begin
      poly = (cfg.variant == VAR_CRC16) ? PolyCrc16 : PolyCcitt;
      c    = crc_in ^ {data, {(CrcW-ByteW){1'b0}}};
      for (int k = 0; k < ByteW; k++) begin
        c = c[CrcW-1] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

>>> design/crc16_bytewise_configurable.sv
// Top level: byte-wise configurable CRC-16 engine with valid/stall channels.
`timescale 1ns / 1ps
// Takes one message byte per transaction and folds it into a 16-bit running
// CRC (CCITT 0x1021 or CRC-16 0x8005, MSB-first or reflected LSB-first, as
// the configuration registers select). A transaction with end_of_message set
// closes the message and produces one result transaction carrying the
// finished CRC, optionally inverted; a bare end marker (byte_present low)
// closes a message too, including an empty one. Transactions with neither
// flag set are dropped. Throughput is one transaction per clock while the
// result channel is not stalled: the input register feeds a combinational
// 8-bit unrolled update whose output lands in the running CRC register and,
// on message end, in the result register. Result valid rises when the
// closing transaction passes into the free result register. Registers at
// byte addresses 0x0 (variant), 0x4 (lsb_first) and 0x8 (invert_result);
// change them only while no transaction is in flight.
module crc16_bytewise_configurable
  import c16b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_byte_present,
  input  logic             in_end_of_message,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CrcW-1:0]  out_crc_value,
  // configuration port
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready
);

  c16b_cfg_t cfg;

  c16b_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input register stage.
  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_present_r;
  logic             s1_eom_r;

  // Running state and result register.
  logic [CrcW-1:0]  crc_r, crc_nxt;
  logic             inside_r, inside_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CrcW-1:0]  out_crc_r, out_crc_nxt;

  logic             advance;
  logic             in_take;
  logic             active;
  logic [CrcW-1:0]  base_crc;
  logic [CrcW-1:0]  folded_crc;
  logic [CrcW-1:0]  msg_crc;

  // The input stage moves on whenever the result register is free or drains.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Idle items (no byte, no end) leave the state untouched.
  assign active   = s1_valid_r && advance && (s1_present_r || s1_eom_r);
  // First item of a message starts from the variant's start value.
  assign base_crc = inside_r ? crc_r : start_value(cfg);

  c16b_fold u_fold (
    .crc_in  (base_crc),
    .data    (s1_byte_r),
    .cfg     (cfg),
    .crc_out (folded_crc)
  );

  assign msg_crc = s1_present_r ? folded_crc : base_crc;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    crc_nxt       = crc_r;
    inside_nxt    = inside_r;
    out_crc_nxt   = out_crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (active) begin
      crc_nxt    = msg_crc;
      inside_nxt = !s1_eom_r;
      if (s1_eom_r) begin
        out_valid_nxt = 1'b1;
        out_crc_nxt   = cfg.invert_result ? (msg_crc ^ InvertMask) : msg_crc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      crc_r       <= '0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      crc_r       <= crc_nxt;
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r    <= in_data_byte;
      s1_present_r <= in_byte_present;
      s1_eom_r     <= in_end_of_message;
    end
    out_crc_r <= out_crc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule
